### rtl/stk_pkg.sv
package stk_pkg;

    // longest symbol or string body that is kept
    localparam int MAX_LEN = 64;
    localparam int LEN_RAW_W = $clog2(MAX_LEN + 1);
    localparam int LEN_W = (LEN_RAW_W < 2) ? 2 : LEN_RAW_W;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    // result kinds
    localparam logic [3:0] K_OPEN    = 4'd0;
    localparam logic [3:0] K_CLOSE   = 4'd1;
    localparam logic [3:0] K_DOT     = 4'd2;
    localparam logic [3:0] K_QUOTE   = 4'd3;
    localparam logic [3:0] K_BQUOTE  = 4'd4;
    localparam logic [3:0] K_COMMA   = 4'd5;
    localparam logic [3:0] K_SYMCHAR = 4'd6;
    localparam logic [3:0] K_STRCHAR = 4'd7;
    localparam logic [3:0] K_NUMBER  = 4'd8;
    localparam logic [3:0] K_SYMEND  = 4'd9;
    localparam logic [3:0] K_NIL     = 4'd10;
    localparam logic [3:0] K_STREND  = 4'd11;
    localparam logic [3:0] K_END     = 4'd12;
    localparam logic [3:0] K_BAD     = 4'd13;
    localparam logic [3:0] K_LONG    = 4'd14;

    // character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_L   = 8'h6C;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         data_byte;
        logic signed [31:0] number_value;
        logic               last_of_run;
    } stk_result_t;

    // what one input beat produces
    typedef struct packed {
        logic [1:0]  count;
        stk_result_t first;
        stk_result_t second;
    } stk_step_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        logic hit;
        hit = is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z))
              || ((c >= CH_UC_A) && (c <= CH_UC_Z));
        case (c)
            8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D,
            8'h5F, 8'h3D, 8'h2B, 8'h2F, 8'h3F, 8'h3C, 8'h3E, 8'h3A: hit = 1'b1;
            default: ;
        endcase
        is_sym = hit;
    endfunction

    function automatic logic [7:0] nil_char(input logic [1:0] idx);
        case (idx)
            2'd0:    nil_char = CH_LC_N;
            2'd1:    nil_char = CH_LC_I;
            default: nil_char = CH_LC_L;
        endcase
    endfunction

    function automatic stk_result_t mk_result(input logic [3:0] kind,
                                              input logic [7:0] data,
                                              input logic [31:0] value);
        stk_result_t r;
        r.kind         = kind;
        r.data_byte    = data;
        r.number_value = value;
        r.last_of_run  = 1'b0;
        mk_result = r;
    endfunction

endpackage

### rtl/stk_lexer.sv
module stk_lexer
    import stk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output stk_step_t  step
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SYM,
        MODE_STR,
        MODE_CMT
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             neg_reg, neg_next;
    logic             all_reg, all_next;
    logic             seen_reg, seen_next;
    logic [31:0]      acc_reg, acc_next;
    logic [1:0]       nil_reg, nil_next;

    // symbol character append, from current state or from a fresh symbol
    logic             start_sel;
    logic [LEN_W-1:0] base_len;
    logic             base_neg, base_all, base_seen;
    logic [31:0]      base_acc;
    logic [1:0]       base_nil;
    logic [LEN_W-1:0] add_len;
    logic             add_neg, add_all, add_seen;
    logic [31:0]      add_acc;
    logic [1:0]       add_nil;

    stk_result_t      cls_res;
    logic             is_s;
    logic             at_limit;

    // idle-mode handling of a byte
    logic             idle_emit;
    stk_result_t      idle_res;
    mode_t            idle_mode;
    logic             idle_start;
    logic             idle_len_clr;

    logic             pre_v, main_v;
    stk_result_t      pre_res, main_res;
    logic             take_add;

    always_comb begin
        start_sel = (mode_reg != MODE_SYM);
        base_len  = start_sel ? '0 : len_reg;
        base_neg  = start_sel ? 1'b0 : neg_reg;
        base_all  = start_sel ? 1'b1 : all_reg;
        base_seen = start_sel ? 1'b0 : seen_reg;
        base_acc  = start_sel ? 32'd0 : acc_reg;
        base_nil  = start_sel ? 2'd0 : nil_reg;

        add_neg  = base_neg;
        add_all  = base_all;
        add_seen = base_seen;
        add_acc  = base_acc;
        if (is_digit(char_in)) begin
            add_acc  = (base_acc << 3) + (base_acc << 1)
                       + {24'd0, char_in - CH_ZERO};
            add_seen = 1'b1;
        end else if (base_len == '0 && (char_in == CH_MINUS || char_in == CH_PLUS)) begin
            add_neg = (char_in == CH_MINUS);
        end else begin
            add_all = 1'b0;
        end
        add_nil = base_nil;
        if (base_len < LEN_W'(3) && base_nil == base_len[1:0]
            && char_in == nil_char(base_len[1:0])) begin
            add_nil = base_nil + 2'd1;
        end
        add_len = base_len + LEN_W'(1);
    end

    // classification of the finished symbol
    always_comb begin
        if (len_reg == LEN_W'(3) && nil_reg == 2'd3) begin
            cls_res = mk_result(K_NIL, 8'd0, 32'd0);
        end else if (all_reg && seen_reg) begin
            cls_res = mk_result(K_NUMBER, 8'd0, neg_reg ? (32'd0 - acc_reg) : acc_reg);
        end else begin
            cls_res = mk_result(K_SYMEND, 8'd0, 32'd0);
        end
    end

    always_comb begin
        is_s         = is_sym(char_in);
        idle_emit    = 1'b1;
        idle_res     = mk_result(K_BAD, char_in, 32'd0);
        idle_mode    = MODE_IDLE;
        idle_start   = 1'b0;
        idle_len_clr = 1'b0;
        case (char_in)
            CH_LPAREN: idle_res = mk_result(K_OPEN, 8'd0, 32'd0);
            CH_RPAREN: idle_res = mk_result(K_CLOSE, 8'd0, 32'd0);
            CH_DOT:    idle_res = mk_result(K_DOT, 8'd0, 32'd0);
            CH_QUOTE:  idle_res = mk_result(K_QUOTE, 8'd0, 32'd0);
            CH_BQUOTE: idle_res = mk_result(K_BQUOTE, 8'd0, 32'd0);
            CH_COMMA:  idle_res = mk_result(K_COMMA, 8'd0, 32'd0);
            CH_DQUOTE: begin
                idle_emit    = 1'b0;
                idle_mode    = MODE_STR;
                idle_len_clr = 1'b1;
            end
            CH_SEMI: begin
                idle_emit = 1'b0;
                idle_mode = MODE_CMT;
            end
            CH_SPACE, CH_TAB, CH_NL: idle_emit = 1'b0;
            default: begin
                if (is_s) begin
                    idle_res   = mk_result(K_SYMCHAR, char_in, 32'd0);
                    idle_mode  = MODE_SYM;
                    idle_start = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        at_limit  = (len_reg >= LEN_W'(MAX_LEN));
        mode_next = mode_reg;
        len_next  = len_reg;
        take_add  = 1'b0;
        pre_v     = 1'b0;
        pre_res   = cls_res;
        main_v    = 1'b0;
        main_res  = mk_result(K_END, 8'd0, 32'd0);

        if (end_of_input) begin
            if (mode_reg == MODE_SYM) begin
                pre_v = 1'b1;
            end else if (mode_reg == MODE_STR) begin
                pre_v   = 1'b1;
                pre_res = mk_result(K_LONG, 8'd0, 32'd0);
            end
            main_v    = 1'b1;
            mode_next = MODE_IDLE;
            len_next  = '0;
        end else begin
            unique case (mode_reg)
                MODE_SYM: begin
                    if (is_s) begin
                        main_v = 1'b1;
                        if (at_limit) begin
                            main_res  = mk_result(K_LONG, 8'd0, 32'd0);
                            mode_next = MODE_IDLE;
                            len_next  = '0;
                        end else begin
                            main_res = mk_result(K_SYMCHAR, char_in, 32'd0);
                            take_add = 1'b1;
                        end
                    end else begin
                        // the ending byte is lexed again as in idle mode
                        pre_v     = 1'b1;
                        main_v    = idle_emit;
                        main_res  = idle_res;
                        mode_next = idle_mode;
                        if (idle_len_clr) begin
                            len_next = '0;
                        end
                    end
                end
                MODE_STR: begin
                    main_v   = 1'b1;
                    if (char_in == CH_DQUOTE) begin
                        main_res  = mk_result(K_STREND, 8'd0, 32'd0);
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                    end else if (at_limit) begin
                        main_res  = mk_result(K_LONG, 8'd0, 32'd0);
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                    end else begin
                        main_res = mk_result(K_STRCHAR, char_in, 32'd0);
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                MODE_CMT: begin
                    if (char_in == CH_NL) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    main_v    = idle_emit;
                    main_res  = idle_res;
                    mode_next = idle_mode;
                    take_add  = idle_start;
                    if (idle_len_clr) begin
                        len_next = '0;
                    end
                end
                default: ;
            endcase
        end

        if (take_add) begin
            len_next = add_len;
        end
        neg_next  = take_add ? add_neg  : neg_reg;
        all_next  = take_add ? add_all  : all_reg;
        seen_next = take_add ? add_seen : seen_reg;
        acc_next  = take_add ? add_acc  : acc_reg;
        nil_next  = take_add ? add_nil  : nil_reg;
    end

    // pack results in order, final one flagged
    always_comb begin
        step.count  = {1'b0, pre_v} + {1'b0, main_v};
        step.first  = pre_v ? pre_res : main_res;
        step.second = main_res;
        step.first.last_of_run  = !(pre_v && main_v);
        step.second.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            neg_reg  <= 1'b0;
            all_reg  <= 1'b1;
            seen_reg <= 1'b0;
            acc_reg  <= 32'd0;
            nil_reg  <= 2'd0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            neg_reg  <= neg_next;
            all_reg  <= all_next;
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
            nil_reg  <= nil_next;
        end
    end

endmodule

### rtl/stk_result_fifo.sv
module stk_result_fifo
    import stk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_en,
    input  stk_step_t   push_step,
    input  logic        pop,
    output logic        out_valid,
    output stk_result_t head,
    output logic        room
);

    stk_result_t        mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [1:0]         push_n;
    logic               pop_do;
    logic [FIFO_AW-1:0] wr_ptr_b;

    assign push_n    = push_en ? push_step.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop_do    = pop && out_valid;
    assign head      = mem_reg[rd_ptr_reg];
    // space for the two results one beat can cause
    assign room      = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + FIFO_AW'(1);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_step.first;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_b] <= push_step.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            if (pop_do) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (FIFO_AW + 1)'(push_n)
                         - (FIFO_AW + 1)'(pop_do);
        end
    end

endmodule

### rtl/sexpr_tokenizer_core.sv
// s-expression lexer, one character beat in, zero to two token beats out
// path: a beat accepted into the input register is lexed once the result queue
//   has room, and its results reach m_ from the head of that queue
// throughput: one input beat per cycle while each causes at most one result and
//   m_ready keeps the queue from filling; a beat with two results leaves as two beats of the single-result output port
// reset: aresetn synchronous active low; lexer returns to idle, queue empties
module sexpr_tokenizer_core
    import stk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic               s_end_of_input,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_kind,
    output logic [7:0]         m_data_byte,
    output logic signed [31:0] m_number_value,
    output logic               m_last_of_run
);

    // input register holding one beat
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        eoi_reg;

    logic        step_en;
    logic        room;
    stk_step_t   step;
    stk_result_t head;

    // lex the held beat once the queue can take both possible results
    assign step_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
            eoi_reg  <= s_end_of_input;
        end
    end

    // mode, symbol length, sign, digit flags, value and nil match
    stk_lexer u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .char_in      (char_reg),
        .end_of_input (eoi_reg),
        .step         (step)
    );

    // small result queue, also decouples m_ready from the input side
    stk_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (step_en),
        .push_step (step),
        .pop       (m_ready),
        .out_valid (m_valid),
        .head      (head),
        .room      (room)
    );

    assign m_kind         = head.kind;
    assign m_data_byte    = head.data_byte;
    assign m_number_value = head.number_value;
    assign m_last_of_run  = head.last_of_run;

`ifndef SYNTH
    // a held beat that is not lexed stays held
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step_en) |=> in_valid_reg)
        else $error("held input beat lost");

    // end of stream always closes a run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == K_END) |-> m_last_of_run)
        else $error("end token not last of run");

    // only a classification or an abandon mark can lead a two-result run
    a_lead_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |->
        (m_kind == K_NUMBER || m_kind == K_SYMEND || m_kind == K_NIL
         || m_kind == K_LONG))
        else $error("unexpected leading result");

    // number value only carried on number tokens
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_NUMBER) |-> (m_number_value == 32'sd0))
        else $error("stray number value");
`endif

endmodule

### test/sexpr_token_checker.sv
// watches both channels of the lexer, predicts token beats and compares them
module sexpr_token_checker
    import stk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic               s_end_of_input,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_kind,
    input  logic [7:0]         m_data_byte,
    input  logic signed [31:0] m_number_value,
    input  logic               m_last_of_run,
    output int                 fail_count,
    output int                 expected_left
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_SYMBOL,
        LEX_STRING,
        LEX_COMMENT
    } lex_mode_t;

    localparam string SYM_EXTRA = "!@#$%^&*-_=+/?<>:";
    localparam string NIL_WORD  = "nil";

    // lexer state mirror
    lex_mode_t   mode;
    int          tok_len;
    logic        neg_sign;
    logic        all_dig;
    logic        seen_dig;
    logic [31:0] accum;
    int          nil_step;

    // tokens caused by the beat being lexed, then the queue of those not yet seen
    stk_result_t step_res [2];
    int          n_step;
    stk_result_t expected_tokens [$];

    function automatic logic is_symbol_byte(input logic [7:0] c);
        logic hit;
        hit = ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LC_A) && (c <= CH_LC_Z))
              || ((c >= CH_UC_A) && (c <= CH_UC_Z));
        for (int i = 0; i < SYM_EXTRA.len(); i++) begin
            if (c == SYM_EXTRA[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic emit(input logic [3:0] kind, input logic [7:0] data, input logic [31:0] val);
        stk_result_t r;
        r.kind         = kind;
        r.data_byte    = data;
        r.number_value = val;
        r.last_of_run  = 1'b0;
        step_res[n_step] = r;
        n_step++;
    endtask

    task automatic add_symbol_byte(input logic [7:0] c);
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            accum    = accum * 32'd10 + 32'(c - CH_ZERO);
            seen_dig = 1'b1;
        end else if ((tok_len == 0) && ((c == CH_MINUS) || (c == CH_PLUS))) begin
            neg_sign = (c == CH_MINUS);
        end else begin
            all_dig = 1'b0;
        end
        if ((tok_len < 3) && (nil_step == tok_len) && (c == NIL_WORD[tok_len]))
            nil_step = tok_len + 1;
        tok_len++;
    endtask

    task automatic close_symbol();
        if ((tok_len == 3) && (nil_step == 3))
            emit(K_NIL, 8'd0, 32'd0);
        else if (all_dig && seen_dig)
            emit(K_NUMBER, 8'd0, neg_sign ? -accum : accum);
        else
            emit(K_SYMEND, 8'd0, 32'd0);
        mode = LEX_IDLE;
    endtask

    task automatic lex_idle_byte(input logic [7:0] c);
        case (c)
            CH_LPAREN: emit(K_OPEN, 8'd0, 32'd0);
            CH_RPAREN: emit(K_CLOSE, 8'd0, 32'd0);
            CH_DOT:    emit(K_DOT, 8'd0, 32'd0);
            CH_QUOTE:  emit(K_QUOTE, 8'd0, 32'd0);
            CH_BQUOTE: emit(K_BQUOTE, 8'd0, 32'd0);
            CH_COMMA:  emit(K_COMMA, 8'd0, 32'd0);
            CH_DQUOTE: begin
                mode    = LEX_STRING;
                tok_len = 0;
            end
            CH_SEMI:   mode = LEX_COMMENT;
            CH_SPACE, CH_TAB, CH_NL: ;
            default: begin
                if (is_symbol_byte(c)) begin
                    tok_len  = 0;
                    neg_sign = 1'b0;
                    all_dig  = 1'b1;
                    seen_dig = 1'b0;
                    accum    = 32'd0;
                    nil_step = 0;
                    add_symbol_byte(c);
                    mode = LEX_SYMBOL;
                    emit(K_SYMCHAR, c, 32'd0);
                end else begin
                    emit(K_BAD, c, 32'd0);
                end
            end
        endcase
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        n_step = 0;
        if (eoi) begin
            if (mode == LEX_SYMBOL)
                close_symbol();
            else if (mode == LEX_STRING)
                emit(K_LONG, 8'd0, 32'd0);
            mode    = LEX_IDLE;
            tok_len = 0;
            emit(K_END, 8'd0, 32'd0);
        end else begin
            case (mode)
                LEX_SYMBOL: begin
                    if (!is_symbol_byte(c)) begin
                        close_symbol();
                        lex_idle_byte(c);
                    end else if (tok_len >= MAX_LEN) begin
                        emit(K_LONG, 8'd0, 32'd0);
                        mode    = LEX_IDLE;
                        tok_len = 0;
                    end else begin
                        add_symbol_byte(c);
                        emit(K_SYMCHAR, c, 32'd0);
                    end
                end
                LEX_STRING: begin
                    if (c == CH_DQUOTE) begin
                        emit(K_STREND, 8'd0, 32'd0);
                        mode    = LEX_IDLE;
                        tok_len = 0;
                    end else if (tok_len >= MAX_LEN) begin
                        emit(K_LONG, 8'd0, 32'd0);
                        mode    = LEX_IDLE;
                        tok_len = 0;
                    end else begin
                        tok_len++;
                        emit(K_STRCHAR, c, 32'd0);
                    end
                end
                LEX_COMMENT: begin
                    if (c == CH_NL) mode = LEX_IDLE;
                end
                default: lex_idle_byte(c);
            endcase
        end
        if (n_step > 0) step_res[n_step-1].last_of_run = 1'b1;
        for (int i = 0; i < n_step; i++) expected_tokens.push_back(step_res[i]);
    endtask

    task automatic check_token();
        stk_result_t want;
        if (expected_tokens.size() == 0) begin
            $error("token beat with none expected: kind %0d data %0d", m_kind, m_data_byte);
            fail_count++;
        end else begin
            want = expected_tokens.pop_front();
            if (m_kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, m_kind);
                fail_count++;
            end
            if (m_data_byte !== want.data_byte) begin
                $error("data_byte: expected %0d, got %0d", want.data_byte, m_data_byte);
                fail_count++;
            end
            if (m_number_value !== want.number_value) begin
                $error("number_value: expected %0d, got %0d",
                       $signed(want.number_value), m_number_value);
                fail_count++;
            end
            if (m_last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, m_last_of_run);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode     = LEX_IDLE;
            tok_len  = 0;
            neg_sign = 1'b0;
            all_dig  = 1'b1;
            seen_dig = 1'b0;
            accum    = 32'd0;
            nil_step = 0;
            expected_tokens.delete();
        end else begin
            // output first: a beat taken in now cannot have a token out yet
            if (m_valid && m_ready) check_token();
            if (s_valid && s_ready) lex_byte(s_char_in, s_end_of_input);
        end
        expected_left = expected_tokens.size();
    end

endmodule

### test/tb_sexpr_tokenizer_core.sv
module tb_sexpr_tokenizer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import stk_pkg::*;

    // run aborts here; far above the slowest legal run
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_BEATS     = 1700;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_in      = 8'd0;
    logic               s_end_of_input = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [3:0]         m_kind;
    logic [7:0]         m_data_byte;
    logic signed [31:0] m_number_value;
    logic               m_last_of_run;

    int          fail_count;
    int          expected_left;
    logic [31:0] cycle_count = 32'd0;

    // sender burst bookkeeping
    int burst_left = 0;
    int beats_sent = 0;
    bit in_comment = 1'b0;

    // receiver stall style, changed now and then
    int ready_style = 0;
    int ready_hold  = 0;

    sexpr_tokenizer_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_number_value (m_number_value),
        .m_last_of_run  (m_last_of_run)
    );

    sexpr_token_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_number_value (m_number_value),
        .m_last_of_run  (m_last_of_run),
        .fail_count     (fail_count),
        .expected_left  (expected_left)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog and cycle count
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 32'd1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sexpr_tokenizer_core verification failed");
            $finish;
        end
    end

    // receiver: always ready, coin flip, mostly stalled, or a fixed pattern
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_style <= $urandom_range(0, 3);
            ready_hold  <= $urandom_range(16, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ~(cycle_count[2] & cycle_count[0]);
        endcase
    end

    // one input beat; gaps between bursts, valid held high inside a burst
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_char_in      <= c;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        if (!in_comment) beats_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_beat(txt[i], 1'b0);
    endtask

    // hold off the sender until every token has come out
    task automatic drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_sym_byte();
        string extra;
        extra = "!@#$%^&*-_=+/?<>:";
        case ($urandom_range(0, 3))
            0:       return CH_LC_A + 8'($urandom_range(0, 25));
            1:       return CH_UC_A + 8'($urandom_range(0, 25));
            2:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return extra[$urandom_range(0, extra.len() - 1)];
        endcase
    endfunction

    // what ends a symbol: mostly whitespace, sometimes a token, a stray byte or end
    task automatic send_delim();
        case ($urandom_range(0, 15))
            6:       send_beat(CH_TAB, 1'b0);
            7:       send_beat(CH_NL, 1'b0);
            8:       send_beat(CH_LPAREN, 1'b0);
            9:       send_beat(CH_RPAREN, 1'b0);
            10:      send_beat(8'($urandom_range(0, 255)), 1'b1);
            11:      send_beat(8'($urandom_range(0, 255)), 1'b0);
            12:      send_beat(CH_COMMA, 1'b0);
            13:      send_beat(CH_DOT, 1'b0);
            default: send_beat(CH_SPACE, 1'b0);
        endcase
    endtask

    initial begin
        string       punct;
        logic [7:0]  b;
        int          n;
        int          sel;

        punct = "().'`,";
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every single-char token, nil, a negative number,
        // bad bytes at both ends, a string holding nul, a comment,
        // end inside a string and a lone sign closed by end of input
        send_text("().'`,");
        send_text("nil)");
        send_text("-7 ");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CH_DQUOTE, 1'b0);
        send_beat(CH_LC_A, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CH_DQUOTE, 1'b0);
        send_text(";x\n");
        send_text("\"b");
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        send_text("+");
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        drain();

        // random token stream, mostly well formed
        while (beats_sent < N_BEATS) begin
            sel = $urandom_range(0, 99);
            if (sel < 24) begin
                // number, optional sign, occasionally long enough to wrap
                case ($urandom_range(0, 2))
                    1:       send_beat(CH_MINUS, 1'b0);
                    2:       send_beat(CH_PLUS, 1'b0);
                    default: ;
                endcase
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
                repeat (n) send_beat(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                send_delim();
            end else if (sel < 38) begin
                repeat ($urandom_range(1, 8)) send_beat(random_sym_byte(), 1'b0);
                send_delim();
            end else if (sel < 46) begin
                // nil and its near misses
                case ($urandom_range(0, 5))
                    0:       send_text("ni");
                    1:       send_text("nils");
                    2:       send_text("nIl");
                    3:       send_text("anil");
                    default: send_text("nil");
                endcase
                send_delim();
            end else if (sel < 58) begin
                send_beat(CH_DQUOTE, 1'b0);
                repeat ($urandom_range(0, 10)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_DQUOTE);
                    send_beat(b, 1'b0);
                end
                if ($urandom_range(0, 7) == 0)
                    send_beat(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_beat(CH_DQUOTE, 1'b0);
            end else if (sel < 60) begin
                // tokens right around the length limit
                n = MAX_LEN - 1 + $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 0) begin
                    repeat (n) send_beat(random_sym_byte(), 1'b0);
                    send_delim();
                end else begin
                    send_beat(CH_DQUOTE, 1'b0);
                    repeat (n) send_beat(CH_LC_A + 8'($urandom_range(0, 25)), 1'b0);
                    // past the limit the string is dropped, so no closing quote
                    send_beat((n <= MAX_LEN) ? CH_DQUOTE : CH_NL, 1'b0);
                end
            end else if (sel < 72) begin
                send_beat(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
            end else if (sel < 77) begin
                send_beat(CH_SEMI, 1'b0);
                in_comment = 1'b1;
                repeat ($urandom_range(0, 6)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
                    send_beat(b, 1'b0);
                end
                in_comment = 1'b0;
                send_beat(CH_NL, 1'b0);
            end else if (sel < 82) begin
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end else if (sel < 93) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_beat(CH_SPACE, 1'b0);
                    1:       send_beat(CH_TAB, 1'b0);
                    default: send_beat(CH_NL, 1'b0);
                endcase
            end
            if ($urandom_range(0, 149) == 0) drain();
        end

        // let the last tokens out, then keep watching quietly for strays
        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("sexpr_tokenizer_core verification clean");
        else
            $display("sexpr_tokenizer_core verification failed");
        $finish;
    end

endmodule
